### hdl/i2cms_pkg.sv
`timescale 1ns / 1ps

package i2cms_pkg;

    // Sizes of the message tables.
    localparam int MAX_MSGS  = 8;
    localparam int MAX_LEN   = 32;
    localparam int BUF_DEPTH = MAX_MSGS * MAX_LEN;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int CNT_W     = $clog2(MAX_MSGS + 1);
    localparam int MSG_W     = 3;
    localparam int PTR_W     = 6;

    // Operation codes carried in the slave tuser.
    localparam logic [2:0] OP_LOAD_DESC = 3'd0;
    localparam logic [2:0] OP_LOAD_BYTE = 3'd1;
    localparam logic [2:0] OP_START     = 3'd2;
    localparam logic [2:0] OP_IRQ       = 3'd3;
    localparam logic [2:0] OP_READ_BYTE = 3'd4;

    // Controller register values.
    localparam logic [7:0] STAT_START_RD = 8'hb0;
    localparam logic [7:0] STAT_START_WR = 8'hf0;
    localparam logic [7:0] STAT_STOP_RD  = 8'h90;
    localparam logic [7:0] STAT_STOP_WR  = 8'hd0;
    localparam logic [7:0] CON_ACK       = 8'haf;
    localparam logic [7:0] CON_NOACK     = 8'h2f;

    // Slave tdata layout, last member in the lowest bits.
    typedef struct packed {
        logic [4:0] pad;
        logic [7:0] rx_byte;
        logic       nack;
        logic [3:0] msg_count;
        logic [5:0] msg_length;
        logic       is_read;
        logic [6:0] dev_addr;
        logic [7:0] buffer_value;
        logic [4:0] byte_index;
        logic [2:0] msg_index;
    } t_in_word;

    // Master tdata layout, last member in the lowest bits.
    typedef struct packed {
        logic [2:0] pad;
        logic [7:0] read_data;
        logic       error;
        logic       done_res;
        logic [7:0] con_value;
        logic       con_write_valid;
        logic [7:0] stat_value;
        logic       stat_write_valid;
        logic [7:0] ds_value;
        logic       ds_write_valid;
    } t_out_word;

    // One registered input item.
    typedef struct packed {
        logic [2:0] operation;
        t_in_word   data;
    } t_item;

    // One message descriptor.
    typedef struct packed {
        logic [6:0]       addr;
        logic             rd;
        logic [LEN_W-1:0] len;
    } t_desc;

    // Byte buffer access for one item.
    typedef struct packed {
        logic              wr_en;
        logic [BUF_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [BUF_AW-1:0] rd_addr;
    } t_mem_req;

    // Result of one item; the buffer read data is merged in later.
    typedef struct packed {
        logic       ds_we;
        logic [7:0] ds_value;
        logic       ds_from_mem;
        logic       stat_we;
        logic [7:0] stat_value;
        logic       con_we;
        logic [7:0] con_value;
        logic       done;
        logic       error;
        logic       rd_from_mem;
    } t_res;

endpackage

### hdl/i2cms_seq.sv
`timescale 1ns / 1ps

module i2cms_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  i2cms_pkg::t_item   i_item,
    output i2cms_pkg::t_res    o_res,
    output i2cms_pkg::t_mem_req o_mem
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_READ  = 3'd2;
    localparam logic [2:0] PH_WRITE = 3'd3;
    localparam logic [2:0] PH_STOP  = 3'd4;

    logic [2:0]                        r_phase, n_phase;
    logic [i2cms_pkg::MSG_W-1:0]       r_msg, n_msg;
    logic [i2cms_pkg::PTR_W-1:0]       r_ptr, n_ptr;
    logic [i2cms_pkg::CNT_W-1:0]       r_total, n_total;
    i2cms_pkg::t_desc                  r_cur, n_cur;
    i2cms_pkg::t_desc                  r_desc [i2cms_pkg::MAX_MSGS];

    i2cms_pkg::t_desc                  load_d;
    i2cms_pkg::t_desc                  nxt_d;
    i2cms_pkg::t_desc                  start_d;
    logic [i2cms_pkg::MSG_W-1:0]       rd_idx;
    logic                              desc_we;
    logic                              is_last;
    logic                              do_start, do_stop, stop_err;
    logic                              do_read_next, do_write_next, do_finish;
    logic [i2cms_pkg::PTR_W-1:0]       rn_ptr;

    // Descriptor being loaded, with the length saturated.
    always_comb begin
        load_d.addr = i_item.data.dev_addr;
        load_d.rd   = i_item.data.is_read;
        if (int'(i_item.data.msg_length) > i2cms_pkg::MAX_LEN) begin
            load_d.len = i2cms_pkg::LEN_W'(i2cms_pkg::MAX_LEN);
        end else begin
            load_d.len = i2cms_pkg::LEN_W'(i_item.data.msg_length);
        end
    end

    // One table read: slot 0 on a start, otherwise the following message.
    assign rd_idx  = (i_item.operation == i2cms_pkg::OP_START) ? '0 : r_msg + 1'b1;
    assign nxt_d   = r_desc[rd_idx];
    assign is_last = ({1'b0, r_msg} + 1'b1) >= r_total;

    // Sequencing of one item.
    always_comb begin
        n_phase       = r_phase;
        n_msg         = r_msg;
        n_ptr         = r_ptr;
        n_total       = r_total;
        n_cur         = r_cur;
        o_res         = '0;
        o_mem         = '0;
        desc_we       = 1'b0;
        do_start      = 1'b0;
        do_stop       = 1'b0;
        stop_err      = 1'b0;
        do_read_next  = 1'b0;
        do_write_next = 1'b0;
        do_finish     = 1'b0;
        rn_ptr        = r_ptr;
        start_d       = nxt_d;

        unique case (i_item.operation)
            i2cms_pkg::OP_LOAD_DESC: begin
                if (int'(i_item.data.msg_index) < i2cms_pkg::MAX_MSGS) begin
                    desc_we = 1'b1;
                    // Keep the copy of the active descriptor current.
                    if (i_item.data.msg_index == r_msg) begin
                        n_cur = load_d;
                    end
                end
            end
            i2cms_pkg::OP_LOAD_BYTE: begin
                if (int'(i_item.data.msg_index) < i2cms_pkg::MAX_MSGS &&
                    int'(i_item.data.byte_index) < i2cms_pkg::MAX_LEN) begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr =
                        i2cms_pkg::BUF_AW'(i_item.data.msg_index) *
                        i2cms_pkg::BUF_AW'(i2cms_pkg::MAX_LEN) +
                        i2cms_pkg::BUF_AW'(i_item.data.byte_index);
                    o_mem.wr_data = i_item.data.buffer_value;
                end
            end
            i2cms_pkg::OP_START: begin
                if (i_item.data.msg_count != '0) begin
                    if (int'(i_item.data.msg_count) > i2cms_pkg::MAX_MSGS) begin
                        n_total = i2cms_pkg::CNT_W'(i2cms_pkg::MAX_MSGS);
                    end else begin
                        n_total = i2cms_pkg::CNT_W'(i_item.data.msg_count);
                    end
                    n_msg    = '0;
                    n_ptr    = '0;
                    n_cur    = nxt_d;
                    do_start = 1'b1;
                end
            end
            i2cms_pkg::OP_IRQ: begin
                unique case (r_phase)
                    PH_START: begin
                        if (i_item.data.nack) begin
                            do_stop  = 1'b1;
                            stop_err = 1'b1;
                        end else if (is_last && ({1'b0, r_ptr} >= {1'b0, r_cur.len})) begin
                            do_stop = 1'b1;
                        end else if (r_cur.rd) begin
                            n_phase      = PH_READ;
                            do_read_next = 1'b1;
                        end else begin
                            n_phase       = PH_WRITE;
                            do_write_next = 1'b1;
                        end
                    end
                    PH_WRITE: begin
                        if (i_item.data.nack) begin
                            do_stop  = 1'b1;
                            stop_err = 1'b1;
                        end else begin
                            do_write_next = 1'b1;
                        end
                    end
                    PH_READ: begin
                        // Store the received byte, then ask for the next one.
                        if (int'(r_ptr) < i2cms_pkg::MAX_LEN) begin
                            o_mem.wr_en   = 1'b1;
                            o_mem.wr_addr =
                                i2cms_pkg::BUF_AW'(r_msg) *
                                i2cms_pkg::BUF_AW'(i2cms_pkg::MAX_LEN) +
                                i2cms_pkg::BUF_AW'(r_ptr);
                            o_mem.wr_data = i_item.data.rx_byte;
                        end
                        rn_ptr       = r_ptr + 1'b1;
                        n_ptr        = rn_ptr;
                        do_read_next = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            i2cms_pkg::OP_READ_BYTE: begin
                if (int'(i_item.data.msg_index) < i2cms_pkg::MAX_MSGS &&
                    int'(i_item.data.byte_index) < i2cms_pkg::MAX_LEN) begin
                    o_mem.rd_en   = 1'b1;
                    o_mem.rd_addr =
                        i2cms_pkg::BUF_AW'(i_item.data.msg_index) *
                        i2cms_pkg::BUF_AW'(i2cms_pkg::MAX_LEN) +
                        i2cms_pkg::BUF_AW'(i_item.data.byte_index);
                    o_res.rd_from_mem = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Ask for the next read byte; the last one goes without ACK.
        if (do_read_next) begin
            if ({1'b0, rn_ptr} < {1'b0, r_cur.len}) begin
                o_res.con_we    = 1'b1;
                o_res.con_value = (({1'b0, rn_ptr} + 1'b1) == {1'b0, r_cur.len}) ?
                                  i2cms_pkg::CON_NOACK : i2cms_pkg::CON_ACK;
            end else begin
                do_finish = 1'b1;
            end
        end

        // Send the next write byte from the buffer.
        if (do_write_next) begin
            if ({1'b0, r_ptr} < {1'b0, r_cur.len}) begin
                o_mem.rd_en       = 1'b1;
                o_mem.rd_addr     = i2cms_pkg::BUF_AW'(r_msg) *
                                    i2cms_pkg::BUF_AW'(i2cms_pkg::MAX_LEN) +
                                    i2cms_pkg::BUF_AW'(r_ptr);
                o_res.ds_we       = 1'b1;
                o_res.ds_from_mem = 1'b1;
                o_res.con_we      = 1'b1;
                o_res.con_value   = i2cms_pkg::CON_ACK;
                n_ptr             = r_ptr + 1'b1;
            end else begin
                do_finish = 1'b1;
            end
        end

        // End of a message: repeated START for the next one, or STOP.
        if (do_finish) begin
            if (!is_last) begin
                n_msg    = r_msg + 1'b1;
                n_ptr    = '0;
                n_cur    = nxt_d;
                do_start = 1'b1;
            end else begin
                do_stop = 1'b1;
            end
        end

        if (do_start) begin
            n_phase          = PH_START;
            o_res.ds_we      = 1'b1;
            o_res.ds_value   = {start_d.addr, 1'b0};
            o_res.stat_we    = 1'b1;
            o_res.stat_value = start_d.rd ? i2cms_pkg::STAT_START_RD :
                                            i2cms_pkg::STAT_START_WR;
        end

        if (do_stop) begin
            n_phase          = PH_STOP;
            o_res.stat_we    = 1'b1;
            o_res.stat_value = r_cur.rd ? i2cms_pkg::STAT_STOP_RD :
                                          i2cms_pkg::STAT_STOP_WR;
            o_res.con_we     = 1'b1;
            o_res.con_value  = i2cms_pkg::CON_ACK;
            o_res.done       = 1'b1;
            o_res.error      = stop_err;
        end
    end

    // Transfer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_msg   <= '0;
            r_ptr   <= '0;
            r_total <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_msg   <= n_msg;
            r_ptr   <= n_ptr;
            r_total <= n_total;
        end
    end

    // Descriptor table and the copy of the active entry.
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_cur <= n_cur;
            if (desc_we) begin
                r_desc[i_item.data.msg_index] <= load_d;
            end
        end
    end

endmodule

### hdl/i2c_master_transfer_sequencer.sv
`timescale 1ns / 1ps

// Channel   Direction  Ports               Content
// -------   ---------  ------------------  ------------------------------------------
// s_axis    in         tvalid/tready/data  operation in tuser, item fields in tdata
// m_axis    out        tvalid/tready/data  controller register writes and status
//
// Every item gives exactly one result, through the input register and then the result
// register. One item is accepted per cycle while the output is not stalled; the input
// register, the byte buffer's registered read and the result register form the two stages.
// Reset is synchronous and active low; it clears the transfer state and both stage
// valid bits. The buffer and descriptor tables hold their contents until written.
// A stalled output holds its result and the pipeline stops behind it.

module i2c_master_transfer_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tuser: operation[2:0]
    input  logic [2:0]  i_s_axis_tuser,
    // tdata: msg_index, byte_index, buffer_value, dev_addr, is_read, msg_length,
    // msg_count, nack, rx_byte, zero fill
    input  logic [47:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: ds_write_valid, ds_value, stat_write_valid, stat_value, con_write_valid,
    // con_value, done_res, error, read_data, zero fill
    output logic [39:0] o_m_axis_tdata
);

    logic                  r_v1;
    logic                  r_v2;
    i2cms_pkg::t_item      r_item;
    i2cms_pkg::t_res       r_res;
    logic [7:0]            r_mem_q;
    logic [7:0]            r_buf [i2cms_pkg::BUF_DEPTH];

    logic                  advance;
    logic                  step;
    i2cms_pkg::t_res       res;
    i2cms_pkg::t_mem_req   mem;
    i2cms_pkg::t_out_word  out_w;

    assign advance         = !r_v2 || i_m_axis_tready;
    assign step            = r_v1 && advance;
    assign o_s_axis_tready = !r_v1 || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_v1 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_item.operation <= i_s_axis_tuser;
            r_item.data      <= i2cms_pkg::t_in_word'(i_s_axis_tdata);
        end
    end

    i2cms_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_item),
        .o_res   (res),
        .o_mem   (mem)
    );

    // Byte buffer with registered read.
    always_ff @(posedge i_clk) begin
        if (step && mem.wr_en) begin
            r_buf[mem.wr_addr] <= mem.wr_data;
        end
        if (step && mem.rd_en) begin
            r_mem_q <= r_buf[mem.rd_addr];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (advance) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= res;
        end
    end

    // Merge the buffer byte into the result word.
    always_comb begin
        out_w                  = '0;
        out_w.ds_write_valid   = r_res.ds_we;
        out_w.ds_value         = r_res.ds_from_mem ? r_mem_q : r_res.ds_value;
        out_w.stat_write_valid = r_res.stat_we;
        out_w.stat_value       = r_res.stat_value;
        out_w.con_write_valid  = r_res.con_we;
        out_w.con_value        = r_res.con_value;
        out_w.done_res         = r_res.done;
        out_w.error            = r_res.error;
        out_w.read_data        = r_res.rd_from_mem ? r_mem_q : 8'h00;
    end

    assign o_m_axis_tvalid = r_v2;
    assign o_m_axis_tdata  = out_w;

endmodule

### hdl/i2cms_checker.sv
`timescale 1ns / 1ps

module i2cms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata
);

    i2cms_pkg::t_out_word w;

    assign w = i2cms_pkg::t_out_word'(o_m_axis_tdata);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds its value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // A finished transfer always writes STOP status and resumes the controller.
    a_done_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w.done_res |-> w.stat_write_valid && w.con_write_valid &&
            w.con_value == i2cms_pkg::CON_ACK && !w.ds_write_valid &&
            (w.stat_value == i2cms_pkg::STAT_STOP_RD ||
             w.stat_value == i2cms_pkg::STAT_STOP_WR))
        else $error("done without STOP");

    // The error flag only comes with a done step.
    a_error_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w.error |-> w.done_res)
        else $error("error without done");

    // A buffer read answer never carries controller writes.
    a_read_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w.read_data != 8'h00 |->
            !w.ds_write_valid && !w.stat_write_valid && !w.con_write_valid)
        else $error("buffer read mixed with register writes");

endmodule

bind i2c_master_transfer_sequencer i2cms_checker u_i2cms_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

### sim/i2c_sequence_checker.sv
`timescale 1ns / 1ps

// Watches both streams of the transfer sequencer, predicts the controller
// register writes for every accepted item and compares them in order.
module i2c_sequence_checker
    import i2cms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    // tuser: operation[2:0]
    input  logic [2:0]  i_s_user,
    // tdata: msg_index, byte_index, buffer_value, dev_addr, is_read, msg_length,
    // msg_count, nack, rx_byte, zero fill
    input  logic [47:0] i_s_data,
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    // tdata: ds_write_valid, ds_value, stat_write_valid, stat_value, con_write_valid,
    // con_value, done_res, error, read_data, zero fill
    input  logic [39:0] i_m_data,
    output int          o_mismatches,
    output int          o_pending
);

    typedef enum logic [2:0] {SQ_IDLE, SQ_ADDR, SQ_RX, SQ_TX, SQ_STOPPED} t_seq_phase;

    // Mirror of the sequencer state.
    t_seq_phase seq_phase = SQ_IDLE;
    int         seq_msg   = 0;
    int         seq_ptr   = 0;
    int         seq_total = 0;

    // Mirror of the descriptor table and the message byte buffer.
    logic [6:0] slot_addr [MAX_MSGS];
    logic       slot_rd   [MAX_MSGS];
    int         slot_len  [MAX_MSGS];
    logic [7:0] msg_bytes [BUF_DEPTH];

    // Register writes predicted but not yet seen on the master side.
    t_out_word  writes_due [$];
    int         mismatch_count = 0;
    int         due_now = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = due_now;

    function automatic bit on_last_message();
        return seq_msg + 1 >= seq_total;
    endfunction

    // START with the shifted address of the current message.
    task automatic begin_message(inout t_out_word r);
        seq_phase          = SQ_ADDR;
        r.ds_write_valid   = 1'b1;
        r.ds_value         = {slot_addr[seq_msg], 1'b0};
        r.stat_write_valid = 1'b1;
        r.stat_value       = slot_rd[seq_msg] ? STAT_START_RD : STAT_START_WR;
    endtask

    // STOP, which also reports the end of the transfer.
    task automatic end_transfer(inout t_out_word r, input logic no_device);
        seq_phase          = SQ_STOPPED;
        r.stat_write_valid = 1'b1;
        r.stat_value       = slot_rd[seq_msg] ? STAT_STOP_RD : STAT_STOP_WR;
        r.con_write_valid  = 1'b1;
        r.con_value        = CON_ACK;
        r.done_res         = 1'b1;
        r.error            = no_device;
    endtask

    task automatic next_message_or_stop(inout t_out_word r);
        if (!on_last_message()) begin
            seq_msg++;
            seq_ptr = 0;
            begin_message(r);
        end else begin
            end_transfer(r, 1'b0);
        end
    endtask

    // Ask for the next read byte; the last one is answered without ACK.
    task automatic request_read(inout t_out_word r);
        if (seq_ptr < slot_len[seq_msg]) begin
            r.con_write_valid = 1'b1;
            r.con_value = (seq_ptr + 1 == slot_len[seq_msg]) ? CON_NOACK : CON_ACK;
        end else begin
            next_message_or_stop(r);
        end
    endtask

    task automatic send_write_byte(inout t_out_word r);
        if (seq_ptr < slot_len[seq_msg]) begin
            r.ds_write_valid  = 1'b1;
            r.ds_value        = msg_bytes[seq_msg * MAX_LEN + seq_ptr];
            seq_ptr++;
            r.con_write_valid = 1'b1;
            r.con_value       = CON_ACK;
        end else begin
            next_message_or_stop(r);
        end
    endtask

    task automatic take_interrupt(input logic nack, input logic [7:0] rx,
                                  inout t_out_word r);
        case (seq_phase)
            SQ_ADDR: begin
                if (nack) begin
                    end_transfer(r, 1'b1);
                end else if (on_last_message() && seq_ptr >= slot_len[seq_msg]) begin
                    end_transfer(r, 1'b0);
                end else if (slot_rd[seq_msg]) begin
                    seq_phase = SQ_RX;
                    request_read(r);
                end else begin
                    seq_phase = SQ_TX;
                    send_write_byte(r);
                end
            end
            SQ_TX: begin
                if (nack) begin
                    end_transfer(r, 1'b1);
                end else begin
                    send_write_byte(r);
                end
            end
            SQ_RX: begin
                if (seq_ptr < MAX_LEN) begin
                    msg_bytes[seq_msg * MAX_LEN + seq_ptr] = rx;
                end
                seq_ptr++;
                request_read(r);
            end
            default: ;
        endcase
    endtask

    // Effect of one accepted item on the mirror, and the result it gives.
    task automatic apply_item(input logic [2:0] op, input t_in_word w,
                              output t_out_word r);
        r = '0;
        case (op)
            OP_LOAD_DESC: begin
                slot_addr[w.msg_index] = w.dev_addr;
                slot_rd[w.msg_index]   = w.is_read;
                slot_len[w.msg_index]  = (w.msg_length > MAX_LEN) ? MAX_LEN : w.msg_length;
            end
            OP_LOAD_BYTE: begin
                msg_bytes[w.msg_index * MAX_LEN + w.byte_index] = w.buffer_value;
            end
            OP_START: begin
                if (w.msg_count != 0) begin
                    seq_total = (w.msg_count > MAX_MSGS) ? MAX_MSGS : w.msg_count;
                    seq_msg   = 0;
                    seq_ptr   = 0;
                    begin_message(r);
                end
            end
            OP_IRQ: begin
                take_interrupt(w.nack, w.rx_byte, r);
            end
            OP_READ_BYTE: begin
                r.read_data = msg_bytes[w.msg_index * MAX_LEN + w.byte_index];
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(input string label, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
        end
    endtask

    // Predict on every accepted input item, compare on every accepted result.
    always @(posedge i_clk) begin : watch_channels
        t_out_word predicted;
        t_out_word want;
        t_out_word got;
        if (!i_rst_n) begin
            seq_phase = SQ_IDLE;
            seq_msg   = 0;
            seq_ptr   = 0;
            seq_total = 0;
            writes_due.delete();
        end else begin
            if (i_s_valid && i_s_ready) begin
                apply_item(i_s_user, t_in_word'(i_s_data), predicted);
                writes_due.push_back(predicted);
            end
            if (i_m_valid && i_m_ready) begin
                got = t_out_word'(i_m_data);
                if (writes_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result expected none, got %h", $time, i_m_data);
                end else begin
                    want = writes_due.pop_front();
                    compare_field("ds_write_valid", want.ds_write_valid,
                                  got.ds_write_valid);
                    compare_field("ds_value", want.ds_value, got.ds_value);
                    compare_field("stat_write_valid", want.stat_write_valid,
                                  got.stat_write_valid);
                    compare_field("stat_value", want.stat_value, got.stat_value);
                    compare_field("con_write_valid", want.con_write_valid,
                                  got.con_write_valid);
                    compare_field("con_value", want.con_value, got.con_value);
                    compare_field("done_res", want.done_res, got.done_res);
                    compare_field("error", want.error, got.error);
                    compare_field("read_data", want.read_data, got.read_data);
                end
            end
        end
        due_now <= writes_due.size();
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

// Drives descriptor loads, buffer loads, transfer starts and controller
// interrupts into the sequencer, with random gaps on both streams.
module testbench;
    import i2cms_pkg::*;

    logic       clk     = 1'b0;
    logic       rst_n   = 1'b0;
    logic       s_valid = 1'b0;
    logic [2:0] s_user  = '0;
    t_in_word   s_data  = '0;
    logic       m_ready = 1'b0;
    wire        s_ready;
    wire        m_valid;
    wire [39:0] m_data;
    int         mismatches;
    int         pending;

    // Stimulus bookkeeping.
    int items_sent    = 0;
    int irqs_sent     = 0;
    int transfers_run = 0;
    int slot_len_copy [MAX_MSGS];

    i2c_master_transfer_sequencer uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    i2c_sequence_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_valid    (s_valid),
        .i_s_ready    (s_ready),
        .i_s_user     (s_user),
        .i_s_data     (s_data),
        .i_m_valid    (m_valid),
        .i_m_ready    (m_ready),
        .i_m_data     (m_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // A stretch of items in the middle runs with neither side idling.
    function automatic bit steady_now();
        return items_sent >= 400 && items_sent < 560;
    endfunction

    always @(posedge clk) begin
        m_ready <= steady_now() || ($urandom_range(99) >= 18);
    end

    // Fields that an operation does not use are filled at random.
    function automatic t_in_word noise_word();
        logic [63:0] raw;
        t_in_word    w;
        raw   = {$urandom, $urandom};
        w     = raw[47:0];
        w.pad = '0;
        return w;
    endfunction

    task automatic put_item(input logic [2:0] op, input t_in_word w);
        if (!steady_now()) begin
            while ($urandom_range(99) < 18) begin
                s_valid <= 1'b0;
                @(posedge clk);
            end
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= w;
        if (op == OP_LOAD_DESC) begin
            slot_len_copy[w.msg_index] = (w.msg_length > MAX_LEN) ? MAX_LEN : w.msg_length;
        end
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic load_slot(input int slot, input int addr, input bit rd, input int len);
        t_in_word w;
        w            = noise_word();
        w.msg_index  = 3'(slot);
        w.dev_addr   = 7'(addr);
        w.is_read    = rd;
        w.msg_length = 6'(len);
        put_item(OP_LOAD_DESC, w);
    endtask

    task automatic load_byte(input int slot, input int pos, input int value);
        t_in_word w;
        w              = noise_word();
        w.msg_index    = 3'(slot);
        w.byte_index   = 5'(pos);
        w.buffer_value = 8'(value);
        put_item(OP_LOAD_BYTE, w);
    endtask

    task automatic start_transfer(input int count);
        t_in_word w;
        w           = noise_word();
        w.msg_count = 4'(count);
        put_item(OP_START, w);
    endtask

    task automatic interrupt(input bit nack, input int rx);
        t_in_word w;
        w         = noise_word();
        w.nack    = nack;
        w.rx_byte = 8'(rx);
        put_item(OP_IRQ, w);
        irqs_sent++;
    endtask

    task automatic read_back(input int slot, input int pos);
        t_in_word w;
        w            = noise_word();
        w.msg_index  = 3'(slot);
        w.byte_index = 5'(pos);
        put_item(OP_READ_BYTE, w);
    endtask

    // Start, then as many interrupts as the loaded messages need to reach STOP.
    // A cut run stops early and leaves the next start to hit a busy block.
    task automatic run_transfer(input int count, input int nack_pct, input bit cut);
        int used;
        int irqs;
        used = (count > MAX_MSGS) ? MAX_MSGS : count;
        irqs = 0;
        for (int m = 0; m < used; m++) irqs += slot_len_copy[m] + 1;
        if (cut) irqs = $urandom_range(irqs);
        start_transfer(count);
        repeat (irqs) interrupt($urandom_range(99) < nack_pct, $urandom_range(255));
        transfers_run++;
    endtask

    // Give fresh descriptors and bytes to some of the slots a transfer will use.
    task automatic reshape_slots(input int count);
        int used;
        int len;
        bit rd;
        used = (count > MAX_MSGS) ? MAX_MSGS : count;
        for (int m = 0; m < used; m++) begin
            if ($urandom_range(99) < 60) begin
                len = ($urandom_range(19) == 0) ? $urandom_range(63, 30) : $urandom_range(4);
                rd  = 1'($urandom_range(1));
                load_slot(m, $urandom_range(127), rd, len);
                if (!rd) begin
                    repeat ($urandom_range(2)) begin
                        load_byte(m, $urandom_range(MAX_LEN - 1), $urandom_range(255));
                    end
                end
            end
        end
    endtask

    initial begin : stimulus
        logic [2:0] code;
        int         random_end;
        int         pick;
        int         count;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Interrupt before any transfer, then the undefined operation codes.
        interrupt(1'b0, 0);
        code = OP_READ_BYTE;
        repeat (3) begin
            code++;
            put_item(code, noise_word());
        end

        // Fill every descriptor and every buffer byte once.
        for (int s = 0; s < MAX_MSGS; s++) begin
            load_slot(s, $urandom_range(127), 1'($urandom_range(1)), $urandom_range(3));
        end
        for (int b = 0; b < BUF_DEPTH; b++) begin
            load_byte(b / MAX_LEN, b % MAX_LEN, $urandom_range(255));
        end

        // Write, read with NACK on its last byte, then an empty last message.
        load_slot(0, 127, 1'b0, 2);
        load_byte(0, 0, 255);
        load_byte(0, 1, 0);
        load_slot(1, 0, 1'b1, 2);
        load_slot(2, 0, 1'b0, 0);
        start_transfer(0);
        run_transfer(3, 0, 1'b0);
        read_back(1, 0);
        read_back(1, MAX_LEN - 1);

        // An empty first message goes straight on to the next START.
        load_slot(0, 85, 1'b0, 0);
        load_slot(1, 42, 1'b1, 1);
        run_transfer(2, 0, 1'b0);

        // Oversized count, restarted while busy, then no ACK on the address.
        start_transfer(15);
        interrupt(1'b0, 255);
        start_transfer(1);
        interrupt(1'b1, 0);

        // No ACK on a write byte, then an interrupt after STOP.
        load_slot(0, 17, 1'b0, 3);
        start_transfer(1);
        interrupt(1'b0, 0);
        interrupt(1'b1, 0);
        interrupt(1'b0, 0);
        load_slot(7, 127, 1'b1, 63);

        // Mostly complete transfers with random content, some noise.
        random_end = 750;
        while (items_sent < random_end) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                count = ($urandom_range(9) == 0) ? $urandom_range(15, 9)
                                                 : $urandom_range(4, 1);
                reshape_slots(count);
                run_transfer(count, 3, pick < 8);
            end else if (pick < 88) begin
                repeat ($urandom_range(4, 1)) begin
                    read_back($urandom_range(MAX_MSGS - 1), $urandom_range(MAX_LEN - 1));
                end
            end else begin
                repeat ($urandom_range(3, 1)) put_item(3'($urandom_range(7)), noise_word());
            end
        end
        s_valid <= 1'b0;

        // Drain, then give late extra results a chance to show up.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Run covered %0d items: %0d transfers and %0d controller interrupts,",
                 items_sent, transfers_run, irqs_sent);
        $display("with random gaps on both streams and one stretch without them.");
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // A time limit far beyond what a normal run needs.
    initial begin : watchdog
        #2000000;
        $display("testbench: errors");
        $finish;
    end

endmodule

### sim.f
hdl/i2cms_pkg.sv
hdl/i2cms_seq.sv
hdl/i2c_master_transfer_sequencer.sv
hdl/i2cms_checker.sv
sim/i2c_sequence_checker.sv
sim/testbench.sv
